@@ rtl/bcem_pkg.sv @@
// Shared types, codes and constants of the bivariate censored EM estimator.
package bcem_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 16;
   localparam int INDEX_W  = 5;
   localparam int MASS_W   = 32;
   localparam int ITER_W   = 8;

   localparam logic [MASS_W-1:0] ONE_Q31        = 32'h8000_0000;
   localparam logic [MASS_W-1:0] TOL_RESET      = 32'd2147484;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd10;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_LOAD_OBS = 3'd1,
      OP_LOAD_X   = 3'd2,
      OP_LOAD_Y   = 3'd3,
      OP_RUN      = 3'd4,
      OP_READ     = 3'd5
   } opcode_type;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_CELL    = 1'b1;

   localparam logic CSR_TOLERANCE = 1'b0;
   localparam logic CSR_MAX_ITER  = 1'b1;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  x_value;
      logic [VALUE_W-1:0]  y_value;
      logic                x_event;
      logic                y_event;
      logic [INDEX_W-1:0]  row_index;
      logic [INDEX_W-1:0]  col_index;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [MASS_W-1:0] cell_mass;
      logic [ITER_W-1:0] iterations_run;
      logic [MASS_W-1:0] final_change;
   } rsp_type;

   // Saturates a grown mass at 1.0.
   function automatic logic [MASS_W-1:0] clamp_one(input logic [MASS_W:0] v);
      return (v > {1'b0, ONE_Q31}) ? ONE_Q31 : v[MASS_W-1:0];
   endfunction

endpackage

@@ rtl/bcem_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bcem_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bcem_div.sv @@
// Restoring divider that yields one quotient bit per cycle.
module bcem_div #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] numer,
   input  logic [W-1:0] denom,
   output logic         busy,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff;
   logic [W-1:0]  den_ff;
   logic [W-1:0]  rem_ff;
   logic [CW-1:0] count_ff;
   logic          busy_ff;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         quo_ff   <= numer;
         den_ff   <= denom;
         rem_ff   <= '0;
         count_ff <= CW'(W);
         busy_ff  <= 1'b1;
      end else if (busy_ff) begin
         // The top bit of the trial difference is its sign.
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
         count_ff <= count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/bivariate_censored_em_estimator.sv @@
// Top level: EM estimate of a bivariate censored mass grid over on-chip memories.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | bcem_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | bcem_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Load and clear beats finish in idle; a cell read goes through read-wait and done.
// A run sweeps the work memory (one cell a cycle), then per observation sweeps the
// nx*ny grid, with a data state per region cell and a wait for each divider use;
// the divider is the shared unit that sets the run length.
// Reset is synchronous; the masses read as zero until a run has written every cell.
// A stalled result waits in its output register while load beats are still taken.
module bivariate_censored_em_estimator #(
   parameter int MAX_OBSERVATIONS = 1024,
   parameter int MAX_X_GRID       = 32,
   parameter int MAX_Y_GRID       = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bcem_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bcem_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);

   import bcem_pkg::*;

   localparam int OBS_AW  = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
   localparam int OBS_CW  = $clog2(MAX_OBSERVATIONS + 1);
   localparam int XA_W    = (MAX_X_GRID > 1) ? $clog2(MAX_X_GRID) : 1;
   localparam int YA_W    = (MAX_Y_GRID > 1) ? $clog2(MAX_Y_GRID) : 1;
   localparam int XC_W    = $clog2(MAX_X_GRID + 1);
   localparam int YC_W    = $clog2(MAX_Y_GRID + 1);
   localparam int CELLS   = MAX_X_GRID * MAX_Y_GRID;
   localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CELL_CW = $clog2(CELLS + 1);
   localparam int OBS_W   = 2 * VALUE_W + 2;
   localparam int WORK_W  = OBS_CW + MASS_W;
   localparam int R_W     = MASS_W + CELL_CW;
   localparam int NR_W    = R_W + OBS_CW;
   localparam int DEN1_W  = OBS_CW + XC_W;
   localparam int DEN_W   = DEN1_W + YC_W;
   localparam int DIV_W   = (NR_W > 2 * MASS_W) ? NR_W : 2 * MASS_W;

   typedef enum logic [4:0] {
      S_IDLE, S_READ_WAIT, S_DONE, S_CLEAR_WORK, S_OBS_NEXT, S_OBS_WAIT,
      S_COUNT, S_DEN_A, S_DEN_B, S_QUOT, S_SWEEP, S_SWEEP_DATA, S_SWEEP_DIV,
      S_NR, S_FIN_RD, S_FIN_DATA, S_FIN_DIV, S_LOOP
   } state_type;

   typedef enum logic [1:0] {
      SW_ADD_Q, SW_HIT, SW_SUMR, SW_ADD_DIV
   } sweep_op_type;

   state_type         state_ff;
   sweep_op_type      op_ff;
   logic [MASS_W-1:0] tol_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [OBS_CW-1:0] n_ff;
   logic [XC_W-1:0]   nx_ff;
   logic [YC_W-1:0]   ny_ff;
   logic [OBS_CW-1:0] z_ff;
   logic [XC_W-1:0]   i_ff;
   logic [YC_W-1:0]   j_ff;
   logic [CELL_CW-1:0] c_ff;
   logic [XC_W-1:0]   cx_ff;
   logic [YC_W-1:0]   cy_ff;
   logic [DEN1_W-1:0] den1_ff;
   logic [MASS_W-1:0] q_ff;
   logic [R_W-1:0]    r_ff;
   logic [NR_W-1:0]   nr_ff;
   logic [VALUE_W-1:0] ox_ff;
   logic [VALUE_W-1:0] oy_ff;
   logic              oxe_ff;
   logic              oye_ff;
   logic              spread_ff;
   logic              mass_valid_ff;
   logic              read_ok_ff;
   logic              kind_ff;
   logic [MASS_W-1:0] cell_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [MASS_W-1:0] change_ff;
   logic [MASS_W-1:0] worst_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [VALUE_W-1:0] xgrid_ff [MAX_X_GRID];
   logic [VALUE_W-1:0] ygrid_ff [MAX_Y_GRID];

   logic               accept;
   logic [VALUE_W-1:0] xg_i;
   logic [VALUE_W-1:0] yg_j;
   logic               x_hit;
   logic               y_hit;
   logic               region;
   logic               sweep_end;
   logic [CELL_AW-1:0] cell_addr;
   logic [CELL_AW-1:0] read_addr;
   logic [NR_W-1:0]    nr_prod;
   logic [DEN1_W-1:0]  den1_prod;
   logic [DEN_W-1:0]   den_prod;

   logic               obs_wr_en;
   logic [OBS_W-1:0]   obs_wr_data;
   logic               obs_rd_en;
   logic [OBS_W-1:0]   obs_rd;
   logic               work_wr_en;
   logic [CELL_AW-1:0] work_wr_addr;
   logic [WORK_W-1:0]  work_wr_data;
   logic               work_rd_en;
   logic [CELL_AW-1:0] work_rd_addr;
   logic [WORK_W-1:0]  work_rd;
   logic [OBS_CW-1:0]  hits;
   logic [MASS_W-1:0]  acc;
   logic               mass_wr_en;
   logic [MASS_W-1:0]  mass_next;
   logic               mass_rd_en;
   logic [CELL_AW-1:0] mass_rd_addr;
   logic [MASS_W-1:0]  mass_rd;
   logic [MASS_W-1:0]  fin_base;
   logic [MASS_W-1:0]  diff;

   logic               div_start;
   logic [DIV_W-1:0]   div_numer;
   logic [DIV_W-1:0]   div_denom;
   logic               div_busy;
   logic [DIV_W-1:0]   div_quo;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Region test of the current observation against grid cell (i, j).
   assign xg_i      = xgrid_ff[i_ff[XA_W-1:0]];
   assign yg_j      = ygrid_ff[j_ff[YA_W-1:0]];
   assign x_hit     = oxe_ff ? (xg_i == ox_ff) : (xg_i > ox_ff);
   assign y_hit     = oye_ff ? (yg_j == oy_ff) : (yg_j > oy_ff);
   assign region    = x_hit && y_hit;
   assign sweep_end = (i_ff == nx_ff) || (ny_ff == '0);
   assign cell_addr = CELL_AW'(32'(i_ff) * MAX_Y_GRID + 32'(j_ff));
   assign read_addr = CELL_AW'(32'(req_data.row_index) * MAX_Y_GRID +
                               32'(req_data.col_index));

   assign nr_prod   = {{(NR_W - OBS_CW){1'b0}}, n_ff} * {{(NR_W - R_W){1'b0}}, r_ff};
   assign den1_prod = {{XC_W{1'b0}}, n_ff} *
                      (oxe_ff ? DEN1_W'(1) : {{OBS_CW{1'b0}}, cx_ff});
   assign den_prod  = {{YC_W{1'b0}}, den1_ff} *
                      (oye_ff ? DEN_W'(1) : {{DEN1_W{1'b0}}, cy_ff});

   assign hits = work_rd[WORK_W-1:MASS_W];
   assign acc  = work_rd[MASS_W-1:0];

   // Observation store.
   assign obs_wr_en   = accept && (req_data.opcode == OP_LOAD_OBS) &&
                        (n_ff < OBS_CW'(MAX_OBSERVATIONS));
   assign obs_wr_data = {req_data.y_event, req_data.x_event, req_data.y_value,
                         req_data.x_value};
   assign obs_rd_en   = (state_ff == S_OBS_NEXT) && (z_ff != n_ff);

   // Work store: per cell the double-event hit count and the accumulated share.
   // Each update reads a cell and writes it back once the new value is ready; no
   // other access to the store is issued in between, so no forwarding is needed.
   always_comb begin
      work_wr_en   = 1'b0;
      work_wr_addr = cell_addr;
      work_wr_data = work_rd;
      case (state_ff)
         S_CLEAR_WORK: begin
            work_wr_en   = 1'b1;
            work_wr_addr = c_ff[CELL_AW-1:0];
            work_wr_data = '0;
         end
         S_SWEEP_DATA: begin
            if (op_ff == SW_ADD_Q) begin
               work_wr_en   = 1'b1;
               work_wr_data = {hits, acc + q_ff};
            end else if (op_ff == SW_HIT) begin
               work_wr_en   = 1'b1;
               work_wr_data = {hits + 1'b1, acc};
            end
         end
         S_SWEEP_DIV: begin
            work_wr_en   = !div_busy;
            work_wr_data = {hits, acc + div_quo[MASS_W-1:0]};
         end
         default: begin
         end
      endcase
   end

   assign work_rd_en   = ((state_ff == S_SWEEP) && !sweep_end && region &&
                          (op_ff != SW_SUMR)) || (state_ff == S_FIN_RD && c_ff != CELL_CW'(CELLS));
   assign work_rd_addr = (state_ff == S_FIN_RD) ? c_ff[CELL_AW-1:0] : cell_addr;

   // Mass store.
   assign fin_base   = (state_ff == S_FIN_DIV) ? div_quo[MASS_W-1:0] : '0;
   assign mass_next  = clamp_one({1'b0, fin_base} + {1'b0, acc});
   assign diff       = (mass_next > mass_rd) ? (mass_next - mass_rd) : (mass_rd - mass_next);
   assign mass_wr_en = ((state_ff == S_FIN_DATA) && (hits == '0)) ||
                       ((state_ff == S_FIN_DIV) && !div_busy);
   assign mass_rd_en = ((state_ff == S_SWEEP) && !sweep_end && region &&
                        (op_ff == SW_SUMR || op_ff == SW_ADD_DIV)) ||
                       (state_ff == S_FIN_RD && c_ff != CELL_CW'(CELLS)) ||
                       (accept && req_data.opcode == OP_READ);

   always_comb begin
      if (state_ff == S_IDLE) begin
         mass_rd_addr = read_addr;
      end else if (state_ff == S_FIN_RD) begin
         mass_rd_addr = c_ff[CELL_AW-1:0];
      end else begin
         mass_rd_addr = cell_addr;
      end
   end

   // Divider sources.
   always_comb begin
      div_start = 1'b0;
      div_numer = DIV_W'(ONE_Q31);
      div_denom = DIV_W'(den_prod);
      case (state_ff)
         S_DEN_B: begin
            div_start = (den_prod != '0);
         end
         S_SWEEP_DATA: begin
            div_start = (op_ff == SW_ADD_DIV);
            div_numer = DIV_W'({mass_rd, {(MASS_W - 1){1'b0}}});
            div_denom = DIV_W'(nr_ff);
         end
         S_FIN_DATA: begin
            div_start = (hits != '0);
            div_numer = DIV_W'({hits, {(MASS_W - 1){1'b0}}});
            div_denom = DIV_W'(n_ff);
         end
         default: begin
         end
      endcase
   end

   bcem_ram #(.WIDTH(OBS_W), .DEPTH(MAX_OBSERVATIONS)) u_obs_ram (
      .clock   (clock),
      .wr_en   (obs_wr_en),
      .wr_addr (n_ff[OBS_AW-1:0]),
      .wr_data (obs_wr_data),
      .rd_en   (obs_rd_en),
      .rd_addr (z_ff[OBS_AW-1:0]),
      .rd_data (obs_rd)
   );

   bcem_ram #(.WIDTH(WORK_W), .DEPTH(CELLS)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_wr_en),
      .wr_addr (work_wr_addr),
      .wr_data (work_wr_data),
      .rd_en   (work_rd_en),
      .rd_addr (work_rd_addr),
      .rd_data (work_rd)
   );

   bcem_ram #(.WIDTH(MASS_W), .DEPTH(CELLS)) u_mass_ram (
      .clock   (clock),
      .wr_en   (mass_wr_en),
      .wr_addr (c_ff[CELL_AW-1:0]),
      .wr_data (mass_next),
      .rd_en   (mass_rd_en),
      .rd_addr (mass_rd_addr),
      .rd_data (mass_rd)
   );

   bcem_div #(.W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Grid values.
   always_ff @(posedge clock) begin
      if (accept && req_data.opcode == OP_LOAD_X && nx_ff < XC_W'(MAX_X_GRID)) begin
         xgrid_ff[nx_ff[XA_W-1:0]] <= req_data.x_value;
      end
      if (accept && req_data.opcode == OP_LOAD_Y && ny_ff < YC_W'(MAX_Y_GRID)) begin
         ygrid_ff[ny_ff[YA_W-1:0]] <= req_data.y_value;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff      <= TOL_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_ff      <= csr_data;
            CSR_MAX_ITER:  max_iter_ff <= csr_data[ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= SW_ADD_Q;
         n_ff          <= '0;
         nx_ff         <= '0;
         ny_ff         <= '0;
         z_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         c_ff          <= '0;
         spread_ff     <= 1'b0;
         mass_valid_ff <= 1'b0;
         iter_ff       <= '0;
         change_ff     <= ONE_Q31;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The done state drives the output register itself.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_data.opcode)
                     OP_CLEAR: begin
                        n_ff          <= '0;
                        nx_ff         <= '0;
                        ny_ff         <= '0;
                        iter_ff       <= '0;
                        change_ff     <= ONE_Q31;
                        mass_valid_ff <= 1'b0;
                     end
                     OP_LOAD_OBS: begin
                        if (n_ff < OBS_CW'(MAX_OBSERVATIONS)) begin
                           n_ff <= n_ff + 1'b1;
                        end
                     end
                     OP_LOAD_X: begin
                        if (nx_ff < XC_W'(MAX_X_GRID)) begin
                           nx_ff <= nx_ff + 1'b1;
                        end
                     end
                     OP_LOAD_Y: begin
                        if (ny_ff < YC_W'(MAX_Y_GRID)) begin
                           ny_ff <= ny_ff + 1'b1;
                        end
                     end
                     OP_RUN: begin
                        spread_ff <= 1'b1;
                        iter_ff   <= '0;
                        change_ff <= ONE_Q31;
                        c_ff      <= '0;
                        state_ff  <= S_CLEAR_WORK;
                     end
                     OP_READ: begin
                        read_ok_ff <= mass_valid_ff &&
                                      (32'(req_data.row_index) < 32'(nx_ff)) &&
                                      (32'(req_data.col_index) < 32'(ny_ff));
                        state_ff   <= S_READ_WAIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_READ_WAIT: begin
               kind_ff  <= KIND_CELL;
               cell_ff  <= read_ok_ff ? mass_rd : '0;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.result_kind     <= kind_ff;
                  rsp_data_ff.cell_mass       <= cell_ff;
                  rsp_data_ff.iterations_run  <= iter_ff;
                  rsp_data_ff.final_change    <= change_ff;
                  state_ff                    <= S_IDLE;
               end
            end
            S_CLEAR_WORK: begin
               c_ff <= c_ff + 1'b1;
               if (c_ff == CELL_CW'(CELLS - 1)) begin
                  z_ff     <= '0;
                  state_ff <= S_OBS_NEXT;
               end
            end
            S_OBS_NEXT: begin
               if (z_ff == n_ff) begin
                  c_ff     <= '0;
                  state_ff <= S_FIN_RD;
               end else begin
                  state_ff <= S_OBS_WAIT;
               end
            end
            S_OBS_WAIT: begin
               ox_ff  <= obs_rd[VALUE_W-1:0];
               oy_ff  <= obs_rd[2*VALUE_W-1:VALUE_W];
               oxe_ff <= obs_rd[2*VALUE_W];
               oye_ff <= obs_rd[2*VALUE_W+1];
               i_ff   <= '0;
               j_ff   <= '0;
               cx_ff  <= '0;
               cy_ff  <= '0;
               r_ff   <= '0;
               if (spread_ff) begin
                  state_ff <= S_COUNT;
               end else begin
                  op_ff    <= (obs_rd[2*VALUE_W+1] && obs_rd[2*VALUE_W]) ? SW_HIT : SW_SUMR;
                  state_ff <= S_SWEEP;
               end
            end
            S_COUNT: begin
               if (i_ff != nx_ff) begin
                  cx_ff <= cx_ff + XC_W'(x_hit);
                  i_ff  <= i_ff + 1'b1;
               end
               if (j_ff != ny_ff) begin
                  cy_ff <= cy_ff + YC_W'(y_hit);
                  j_ff  <= j_ff + 1'b1;
               end
               if (i_ff == nx_ff && j_ff == ny_ff) begin
                  state_ff <= S_DEN_A;
               end
            end
            S_DEN_A: begin
               den1_ff  <= den1_prod;
               state_ff <= S_DEN_B;
            end
            S_DEN_B: begin
               if (den_prod == '0) begin
                  z_ff     <= z_ff + 1'b1;
                  state_ff <= S_OBS_NEXT;
               end else begin
                  state_ff <= S_QUOT;
               end
            end
            S_QUOT: begin
               if (!div_busy) begin
                  q_ff     <= div_quo[MASS_W-1:0];
                  i_ff     <= '0;
                  j_ff     <= '0;
                  op_ff    <= SW_ADD_Q;
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               if (sweep_end) begin
                  if (op_ff == SW_SUMR) begin
                     state_ff <= S_NR;
                  end else begin
                     z_ff     <= z_ff + 1'b1;
                     state_ff <= S_OBS_NEXT;
                  end
               end else if (region) begin
                  state_ff <= S_SWEEP_DATA;
               end else if (j_ff + 1'b1 == ny_ff) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_SWEEP_DATA: begin
               if (op_ff == SW_ADD_DIV) begin
                  state_ff <= S_SWEEP_DIV;
               end else begin
                  if (op_ff == SW_SUMR) begin
                     r_ff <= r_ff + {{(R_W - MASS_W){1'b0}}, mass_rd};
                  end
                  if (j_ff + 1'b1 == ny_ff) begin
                     j_ff <= '0;
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP_DIV: begin
               if (!div_busy) begin
                  if (j_ff + 1'b1 == ny_ff) begin
                     j_ff <= '0;
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
                  state_ff <= S_SWEEP;
               end
            end
            S_NR: begin
               nr_ff <= nr_prod;
               i_ff  <= '0;
               j_ff  <= '0;
               if (r_ff == '0) begin
                  z_ff     <= z_ff + 1'b1;
                  state_ff <= S_OBS_NEXT;
               end else begin
                  op_ff    <= SW_ADD_DIV;
                  state_ff <= S_SWEEP;
               end
            end
            S_FIN_RD: begin
               if (c_ff == CELL_CW'(CELLS)) begin
                  if (spread_ff) begin
                     spread_ff     <= 1'b0;
                     mass_valid_ff <= 1'b1;
                  end else begin
                     change_ff <= worst_ff;
                  end
                  state_ff <= S_LOOP;
               end else begin
                  state_ff <= S_FIN_DATA;
               end
            end
            S_FIN_DATA: begin
               if (hits != '0) begin
                  state_ff <= S_FIN_DIV;
               end else begin
                  if (diff > worst_ff) begin
                     worst_ff <= diff;
                  end
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_FIN_RD;
               end
            end
            S_FIN_DIV: begin
               if (!div_busy) begin
                  if (diff > worst_ff) begin
                     worst_ff <= diff;
                  end
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_FIN_RD;
               end
            end
            S_LOOP: begin
               if (change_ff > tol_ff && iter_ff < max_iter_ff) begin
                  iter_ff  <= iter_ff + 1'b1;
                  worst_ff <= '0;
                  c_ff     <= '0;
                  state_ff <= S_CLEAR_WORK;
               end else begin
                  kind_ff  <= KIND_SUMMARY;
                  cell_ff  <= '0;
                  state_ff <= S_DONE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A run never reports more iterations than the cap allows.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.result_kind == KIND_SUMMARY) |->
         (rsp_data_ff.iterations_run <= max_iter_ff))
      else $error("run summary exceeds the iteration cap");

   // A run that stopped below the cap must have converged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.result_kind == KIND_SUMMARY &&
       rsp_data_ff.iterations_run < max_iter_ff) |->
         (rsp_data_ff.final_change <= tol_ff))
      else $error("run stopped early without converging");

   // The shared divider is only started when it is free.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule
